@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion helpers used by the heap queue rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ sv/hmq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_pkg
// shared types, codes and widths of the max-heap priority queue
// ----------------------------------------------------------------------------
package hmq_pkg;

	localparam int KEY_W     = 32;
	localparam int TAG_W     = 16;
	localparam int OP_W      = 2;
	localparam int IDX_W     = 5;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 6;
	localparam int CAP_W     = 6;
	localparam int ENTRY_W   = KEY_W + TAG_W;
	localparam int DEPTH_DEF = 32;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_SORT   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] index;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    out_key;
		logic [TAG_W-1:0]    out_tag;
		logic                last;
		logic [CNT_W-1:0]    count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CMP,
		S_PLACE,
		S_UPD_CMP,
		S_DN_RDR,
		S_DN_CMP,
		S_SRT_RD0,
		S_SRT_TOP,
		S_SRT_LAST,
		S_EM_RD,
		S_EM_OUT,
		S_RESP
	} hmq_state_t;

endpackage
`default_nettype wire

@@ sv/hmq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module hmq_ram #(
	parameter int WIDTH = hmq_pkg::ENTRY_W,
	parameter int DEPTH = hmq_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	import hmq_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/hmq_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_cfg
// apb register slice holding the capacity limit
// ----------------------------------------------------------------------------
module hmq_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [hmq_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [hmq_pkg::PDATA_W-1:0]   pwdata,
	output logic      [hmq_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output logic      [hmq_pkg::CAP_W-1:0]     capacity
);
	import hmq_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             reg_sel;

	// one register, word index sits above the byte offset
	assign reg_sel  = (paddr[2] == REG_CAPACITY);
	assign pready   = 1'b1;
	assign capacity = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = PDATA_W'(cap_q);
		end
	end

endmodule
`default_nettype wire

@@ sv/binary_max_heap_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// max-heap priority queue of (key, tag) entries held in one ram
// ----------------------------------------------------------------------------
// usage:
//   items enter on item/item_valid/item_stall; a beat moves when valid is
//   high and stall is low. results leave on result/result_valid/result_stall
//   through an output register, so a finished result may wait while the next
//   item is taken. capacity is to be written over the apb port while idle;
//   the block does not enforce this. one item is worked at a time; item_stall
//   is high until its work is done, and its last answer beat turns valid in
//   the cycle that item_stall falls.
// work per item:
//   insert: the entry floats up from the tail, one parent read per level
//   update: the entry floats up, stays when the key is unchanged, or sinks
//           down; going down, left and right child share the read port
//   sort of n entries: n heapsort passes, then one beat per entry from
//           slot 0 up; full, bad index, empty sort and the unused code
//           answer with a status beat and leave the heap as is
// reset clears the count and the control state; ram contents are left as is,
// only slots that hold entries are ever read. a stalled result holds, and the
// drain of a sort simply waits on the output register.
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
	parameter int DEPTH = hmq_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire hmq_pkg::item_t              item,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output hmq_pkg::result_t                 result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hmq_pkg::PADDR_W-1:0] paddr,
	input  wire logic [hmq_pkg::PDATA_W-1:0] pwdata,
	output logic      [hmq_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import hmq_pkg::*;

`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > CAP_W) ? CW : CAP_W;
	localparam int IW = (CW > IDX_W) ? CW : IDX_W;

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] x);
		parent_of = (x - AW'(1)) >> 1;
	endfunction

	function automatic logic [LW-1:0] left_of(input logic [AW-1:0] x);
		left_of = {x, 1'b1};
	endfunction

	hmq_state_t state_q, state_d;

	logic [OP_W-1:0]     op_q, op_d;
	entry_t              e_q, e_d;
	entry_t              lchild_q, lchild_d;
	entry_t              top_q, top_d;
	logic [AW-1:0]       n_q, n_d;
	logic [CW-1:0]       sz_q, sz_d;
	logic [CW-1:0]       i_q, i_d;
	logic [CW-1:0]       j_q, j_d;
	logic [CW-1:0]       sortn_q, sortn_d;
	logic [CW-1:0]       count_q, count_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic    out_valid_q;
	result_t out_q, out_d;
	logic    out_load;
	logic    out_free;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	logic [CAP_W-1:0] capacity;
	logic [WW-1:0]    cap_eff;
	logic             full;
	logic             bad_idx;
	logic             ins_ok;
	logic             done;
	logic             dn_go;
	logic [AW-1:0]    dn_n;
	logic [CW-1:0]    dn_sz;
	logic [LW-1:0]    dn_l;
	logic [AW-1:0]    par_n;
	logic [LW-1:0]    l_n, r_n;
	logic             r_ok;
	logic             take_l, take_r;
	logic [KEY_W-1:0] big_key;
	logic [CW-1:0]    i_dec;
	logic             draining;

	hmq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	hmq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capacity saturates at the store depth
	assign cap_eff = (WW'(capacity) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(capacity);
	assign full    = (WW'(count_q) >= cap_eff);
	assign bad_idx = (IW'(item.index) >= IW'(count_q));

	assign par_n = parent_of(n_q);
	assign l_n   = left_of(n_q);
	assign r_n   = l_n + LW'(1);
	assign r_ok  = (r_n < LW'(sz_q));
	assign i_dec = i_q - CW'(1);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign draining     = state_q inside {S_EM_RD, S_EM_OUT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		e_q      <= e_d;
		lchild_q <= lchild_d;
		top_q    <= top_d;
		n_q      <= n_d;
		sz_q     <= sz_d;
		i_q      <= i_d;
		j_q      <= j_d;
		sortn_q  <= sortn_d;
		status_q <= status_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		e_d       = e_q;
		lchild_d  = lchild_q;
		top_d     = top_q;
		n_d       = n_q;
		sz_d      = sz_q;
		i_d       = i_q;
		j_d       = j_q;
		sortn_d   = sortn_q;
		status_d  = status_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_waddr = n_q;
		ram_wdata = e_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		out_load  = 1'b0;
		out_d     = '0;
		done      = 1'b0;
		dn_go     = 1'b0;
		dn_n      = '0;
		dn_sz     = sz_q;
		dn_l      = '0;
		ins_ok    = 1'b0;
		take_l    = 1'b0;
		take_r    = 1'b0;
		big_key   = e_q.key;

		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					op_d     = item.operation;
					e_d.key  = item.key;
					e_d.tag  = item.tag;
					status_d = ST_OK;
					case (item.operation)
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
								state_d  = S_RESP;
							end else begin
								ins_ok  = 1'b1;
								count_d = count_q + CW'(1);
								n_d     = AW'(count_q);
								if (count_q == '0) begin
									state_d = S_PLACE;
								end else begin
									ram_re    = 1'b1;
									ram_raddr = parent_of(AW'(count_q));
									state_d   = S_UP_CMP;
								end
							end
						end
						OP_UPDATE: begin
							if (bad_idx) begin
								status_d = ST_BAD_INDEX;
								state_d  = S_RESP;
							end else begin
								n_d       = AW'(item.index);
								sz_d      = count_q;
								ram_re    = 1'b1;
								ram_raddr = AW'(item.index);
								state_d   = S_UPD_CMP;
							end
						end
						OP_SORT: begin
							count_d = '0;
							if (count_q == '0) begin
								state_d = S_RESP;
							end else begin
								i_d       = count_q;
								sortn_d   = count_q;
								ram_re    = 1'b1;
								ram_raddr = '0;
								state_d   = S_SRT_TOP;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (e_q.key > ram_rdata.key) begin
					// parent drops into the hole, next parent read alongside
					ram_wdata = ram_rdata;
					n_d       = par_n;
					if (par_n == '0) begin
						state_d = S_PLACE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = parent_of(par_n);
					end
				end else begin
					done = 1'b1;
				end
			end
			S_PLACE: begin
				ram_we = 1'b1;
				done   = 1'b1;
			end
			S_UPD_CMP: begin
				if (e_q.key > ram_rdata.key) begin
					if (n_q == '0) begin
						state_d = S_PLACE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = par_n;
						state_d   = S_UP_CMP;
					end
				end else if (e_q.key < ram_rdata.key) begin
					dn_go = 1'b1;
					dn_n  = n_q;
					dn_sz = sz_q;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_RDR: begin
				lchild_d = ram_rdata;
				if (r_ok) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(r_n);
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (lchild_q.key > e_q.key) begin
					take_l  = 1'b1;
					big_key = lchild_q.key;
				end
				if (r_ok && (ram_rdata.key > big_key)) begin
					take_r = 1'b1;
				end
				ram_we = 1'b1;
				if (take_r) begin
					ram_wdata = ram_rdata;
					dn_go     = 1'b1;
					dn_n      = AW'(r_n);
					dn_sz     = sz_q;
				end else if (take_l) begin
					ram_wdata = lchild_q;
					dn_go     = 1'b1;
					dn_n      = AW'(l_n);
					dn_sz     = sz_q;
				end else begin
					done = 1'b1;
				end
			end
			S_SRT_RD0: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = S_SRT_TOP;
			end
			S_SRT_TOP: begin
				top_d     = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = AW'(i_dec);
				state_d   = S_SRT_LAST;
			end
			S_SRT_LAST: begin
				// top goes to the tail, old tail sifts down from the root
				e_d       = ram_rdata;
				ram_we    = 1'b1;
				ram_waddr = AW'(i_dec);
				ram_wdata = top_q;
				dn_go     = 1'b1;
				dn_n      = '0;
				dn_sz     = i_dec;
			end
			S_EM_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(j_q);
				state_d   = S_EM_OUT;
			end
			S_EM_OUT: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_d.status  = ST_OK;
					out_d.out_key = ram_rdata.key;
					out_d.out_tag = ram_rdata.tag;
					out_d.last    = (CW'(j_q + CW'(1)) == sortn_q);
					out_d.count   = '0;
					j_d           = j_q + CW'(1);
					if (CW'(j_q + CW'(1)) == sortn_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_EM_RD;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_d.status = status_q;
					out_d.last   = 1'b1;
					out_d.count  = CNT_W'(count_q);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// step one level down, or settle the held entry here
		if (dn_go) begin
			n_d  = dn_n;
			sz_d = dn_sz;
			dn_l = left_of(dn_n);
			if (dn_l < LW'(dn_sz)) begin
				ram_re    = 1'b1;
				ram_raddr = AW'(dn_l);
				state_d   = S_DN_RDR;
			end else begin
				state_d = S_PLACE;
			end
		end

		if (done) begin
			if (op_q == OP_SORT) begin
				i_d = i_dec;
				if (i_q == CW'(1)) begin
					j_d     = '0;
					state_d = S_EM_RD;
				end else begin
					state_d = S_SRT_RD0;
				end
			end else begin
				state_d = S_RESP;
			end
		end
	end

	`ASSERT_IMPL(a_no_rw_collision, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`ASSERT_NEXT(a_insert_counts, clk, arst_n, ins_ok, count_q == $past(count_q) + CW'(1))
	`ASSERT_IMPL(a_drain_beats, clk, arst_n, result_valid && !result.last, result.count == '0 && draining)

endmodule
`default_nettype wire

@@ tb/tb_binary_max_heap_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// self-checking bench for the max-heap priority queue: a mirror heap in the
// bench predicts every answer beat (insert, update, heapsort drain) and a
// monitor compares each beat field by field, under random sender gaps, random
// result stalls and capacity changes written over apb between phases
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
	import hmq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	item_t               item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [PDATA_W-1:0]  pwdata       = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// mirror of the heap contents and settings
	logic [KEY_W-1:0] heap_keys [DEPTH];
	logic [TAG_W-1:0] heap_tags [DEPTH];
	int unsigned      held = 0;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;
	result_t          awaited [$];

	int          errors = 0;
	int          items_sent = 0;
	int          beats_seen = 0;
	int          sorts_sent = 0;
	int          full_seen = 0;
	int          bad_seen = 0;
	int unsigned quiet = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	logic [15:0] stall_word = '0;
	logic [3:0]  stall_phase = '0;

	binary_max_heap_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic [KEY_W-1:0] k;
		logic [TAG_W-1:0] t;
		k = heap_keys[a];
		t = heap_tags[a];
		heap_keys[a] = heap_keys[b];
		heap_tags[a] = heap_tags[b];
		heap_keys[b] = k;
		heap_tags[b] = t;
	endfunction

	function automatic void float_up(int unsigned n);
		int unsigned p;
		while (n > 0 && heap_keys[n] > heap_keys[(n - 1) / 2]) begin
			p = (n - 1) / 2;
			swap_entries(n, p);
			n = p;
		end
	endfunction

	function automatic void sink_down(int unsigned n, int unsigned size);
		int unsigned big;
		int unsigned l;
		int unsigned r;
		bit moving;
		moving = 1'b1;
		while (moving) begin
			big = n;
			l = 2 * n + 1;
			r = 2 * n + 2;
			if (l < size && heap_keys[l] > heap_keys[big])
				big = l;
			if (r < size && heap_keys[r] > heap_keys[big])
				big = r;
			if (big == n) begin
				moving = 1'b0;
			end else begin
				swap_entries(n, big);
				n = big;
			end
		end
	endfunction

	// advance the mirror heap by one item and queue the answer beats
	function automatic void apply_heap_op(item_t it);
		result_t          r;
		int unsigned      cap;
		int unsigned      n;
		int unsigned      i;
		logic [KEY_W-1:0] old;
		r = '0;
		r.last = 1'b1;
		cap = (cap_reg < DEPTH) ? cap_reg : DEPTH;
		case (it.operation)
			OP_INSERT: begin
				if (held >= cap) begin
					r.status = ST_FULL;
					full_seen++;
				end else begin
					heap_keys[held] = it.key;
					heap_tags[held] = it.tag;
					float_up(held);
					held++;
				end
				r.count = CNT_W'(held);
				awaited.push_back(r);
			end
			OP_UPDATE: begin
				if (it.index >= held) begin
					r.status = ST_BAD_INDEX;
					bad_seen++;
				end else begin
					old = heap_keys[it.index];
					heap_keys[it.index] = it.key;
					heap_tags[it.index] = it.tag;
					if (it.key > old)
						float_up(it.index);
					else if (it.key < old)
						sink_down(it.index, held);
				end
				r.count = CNT_W'(held);
				awaited.push_back(r);
			end
			OP_SORT: begin
				n = held;
				held = 0;
				if (n == 0) begin
					awaited.push_back(r);
				end else begin
					for (i = n; i > 0; i--) begin
						swap_entries(0, i - 1);
						sink_down(0, i - 1);
					end
					for (i = 0; i < n; i++) begin
						r.out_key = heap_keys[i];
						r.out_tag = heap_tags[i];
						r.last = (i + 1 == n);
						awaited.push_back(r);
					end
				end
			end
			default: begin
				r.count = CNT_W'(held);
				awaited.push_back(r);
			end
		endcase
	endfunction

	function automatic item_t make_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [TAG_W-1:0] t, logic [IDX_W-1:0] idx);
		item_t it;
		it.operation = op;
		it.key = k;
		it.tag = t;
		it.index = idx;
		return it;
	endfunction

	// mix of extremes, small integer keys for ties, and full-range values
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 5))
			0: k = '0;
			1: k = '1;
			2: k = KEY_W'($urandom_range(0, 7)) << 16;
			3: k = KEY_W'($urandom_range(0, 3));
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_beat(result_t got);
		result_t want;
		beats_seen++;
		if (awaited.size() == 0) begin
			report_mismatch("unexpected beat", got, '0);
		end else begin
			want = awaited.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.out_key !== want.out_key)
				report_mismatch("out_key", got.out_key, want.out_key);
			if (got.out_tag !== want.out_tag)
				report_mismatch("out_tag", got.out_tag, want.out_tag);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
			if (got.count !== want.count)
				report_mismatch("count", got.count, want.count);
		end
	endtask

	// outputs are sampled at the falling edge, half a period clear of updates
	always @(negedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0)
			check_beat(result);
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		result_stall <= stall_word[stall_phase];
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", quiet);
				$display("binary_max_heap_queue regression: fail");
				$finish;
			end
		end
	end

	task automatic send_item(item_t it);
		bit took;
		apply_heap_op(it);
		items_sent++;
		if (it.operation == OP_SORT)
			sorts_sent++;
		item <= it;
		item_valid <= 1'b1;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = (item_stall === 1'b0);
			@(posedge clk);
		end
	endtask

	task automatic send_beat(item_t it);
		if (gaps_on) begin
			if (burst_left <= 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		send_item(it);
	endtask

	task automatic pause_until_drained();
		item_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(int unsigned value);
		bit ready;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_CAPACITY);
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		ready = 1'b0;
		while (!ready) begin
			@(negedge clk);
			ready = (pready === 1'b1);
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = CAP_W'(value);
	endtask

	// reset capacity, nothing held yet
	task automatic test_empty_heap();
		gaps_on = 1'b0;
		send_item(make_item(OP_SORT, '1, '1, '1));
		send_item(make_item(OP_UPDATE, 32'h0001_0000, 16'h00aa, 5'd0));
		send_item(make_item(OP_UNUSED, '1, '1, '1));
		pause_until_drained();
	endtask

	task automatic test_directed_ops();
		set_capacity(32);
		stall_word <= 16'h3a50;
		send_item(make_item(OP_INSERT, '0, '0, '0));
		send_item(make_item(OP_INSERT, '1, '1, '1));
		send_item(make_item(OP_INSERT, 32'h0001_0000, 16'h1234, 5'd0));
		send_item(make_item(OP_INSERT, 32'h0001_0000, 16'h4321, 5'd0));
		// shrink the root, then grow a leaf past it
		send_item(make_item(OP_UPDATE, '0, 16'h5555, 5'd0));
		send_item(make_item(OP_UPDATE, '1, 16'haaaa, 5'd3));
		// same key, new tag: no movement
		send_item(make_item(OP_UPDATE, heap_keys[1], 16'hbeef, 5'd1));
		send_item(make_item(OP_UPDATE, 32'h1234_5678, 16'h0001, 5'd4));
		send_item(make_item(OP_UPDATE, 32'h1234_5678, 16'h0001, 5'd31));
		send_item(make_item(OP_UNUSED, '0, '0, '0));
		send_item(make_item(OP_SORT, '0, '0, '0));
		pause_until_drained();
	endtask

	task automatic test_small_capacity();
		set_capacity(1);
		send_item(make_item(OP_INSERT, 32'h8000_0000, 16'h0f0f, 5'd0));
		send_item(make_item(OP_INSERT, 32'hffff_0000, 16'hf0f0, 5'd0));
		send_item(make_item(OP_UPDATE, 32'h0000_0001, 16'h7777, 5'd0));
		send_item(make_item(OP_UPDATE, 32'h0000_0001, 16'h7777, 5'd1));
		send_item(make_item(OP_SORT, '0, '0, '0));
		pause_until_drained();
	endtask

	// well-formed rounds: a fill, some updates, maybe noise, usually a sort
	task automatic run_phase(int unsigned cap, int quota, bit idle_sender, bit idle_receiver);
		int               start;
		int unsigned      fills;
		int unsigned      upd;
		int unsigned      i;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] k;
		pause_until_drained();
		set_capacity(cap);
		stall_word <= idle_receiver ? (16'($urandom & $urandom) & 16'hfffe) : 16'h0000;
		gaps_on = idle_sender;
		burst_left = 0;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 2) == 0)
				fills = ((cap > held) ? cap - held : 0) + $urandom_range(0, 2);
			else
				fills = $urandom_range(1, 6);
			for (i = 0; i < fills; i++)
				send_beat(make_item(OP_INSERT, rand_key(), TAG_W'($urandom),
					IDX_W'($urandom)));
			upd = $urandom_range(0, 6);
			for (i = 0; i < upd; i++) begin
				if (held > 0 && $urandom_range(0, 9) != 0)
					idx = IDX_W'($urandom_range(0, held - 1));
				else
					idx = IDX_W'($urandom_range((held > 31) ? 31 : held, 31));
				if (idx < held && $urandom_range(0, 4) == 0)
					k = heap_keys[idx];
				else
					k = rand_key();
				send_beat(make_item(OP_UPDATE, k, TAG_W'($urandom), idx));
			end
			if ($urandom_range(0, 7) == 0)
				send_beat(make_item(OP_W'($urandom_range(0, 2)), rand_key(),
					TAG_W'($urandom), IDX_W'($urandom)));
			if ($urandom_range(0, 3) != 0)
				send_beat(make_item(OP_SORT, $urandom, TAG_W'($urandom),
					IDX_W'($urandom)));
		end
		pause_until_drained();
	endtask

	task automatic test_random_traffic();
		run_phase(32, 90, 1'b1, 1'b1);
		run_phase(32, 80, 1'b0, 1'b0);
		run_phase(1, 45, 1'b1, 1'b1);
		run_phase($urandom_range(2, 31), 90, 1'b1, 1'b0);
		run_phase(32, 95, 1'b0, 1'b1);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_heap();
		test_directed_ops();
		test_small_capacity();
		test_random_traffic();
		pause_until_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d items with %0d sorts, %0d result beats checked",
			items_sent, sorts_sent, beats_seen);
		$display("%0d full answers, %0d bad index answers, capacity from 1 to 32",
			full_seen, bad_seen);
		if (errors == 0 && awaited.size() == 0) begin
			$display("binary_max_heap_queue regression: pass");
		end else begin
			$display("%0d mismatches, %0d beats never seen", errors, awaited.size());
			$display("binary_max_heap_queue regression: fail");
		end
		$finish;
	end

endmodule
